// ===== hdl/fsmc_pkg.sv =====
package fsmc_pkg;

  localparam int TEMP_W = 15;
  localparam int TIMEOUT_W = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_UP    = 3'd1,
    ACT_DOWN  = 3'd2,
    ACT_MODE  = 3'd3,
    ACT_POWER = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SER_NONE   = 2'd0,
    SER_AUTO   = 2'd1,
    SER_MANUAL = 2'd2
  } serial_cmd_t;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_UNSET  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_HOT_TEMP  = 2'd0,
    REG_WARM_TEMP = 2'd1,
    REG_MILD_TEMP = 2'd2,
    REG_TIMEOUT   = 2'd3
  } reg_index_t;

  localparam logic signed [TEMP_W-1:0] HOT_TEMP_RESET  = 15'sd3000;
  localparam logic signed [TEMP_W-1:0] WARM_TEMP_RESET = 15'sd2500;
  localparam logic signed [TEMP_W-1:0] MILD_TEMP_RESET = 15'sd2000;
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RESET   = 16'd10000;

  localparam logic [1:0] LEVEL_MAX = 2'd3;
  localparam logic [1:0] CHIRP_MAX = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] hot_temp;
    logic signed [TEMP_W-1:0] warm_temp;
    logic signed [TEMP_W-1:0] mild_temp;
    logic [TIMEOUT_W-1:0]     absence_timeout;
  } cfg_t;

  // Duty percent for each fan level.
  function automatic logic [6:0] level_duty(input logic [1:0] level);
    logic [6:0] duty;
    case (level)
      2'd0: duty = 7'd0;
      2'd1: duty = 7'd33;
      2'd2: duty = 7'd66;
      2'd3: duty = 7'd100;
      default: duty = 7'd0;
    endcase
    return duty;
  endfunction

endpackage

// ===== hdl/fsmc_ifs.sv =====
interface fsmc_tick_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic              motion;
  logic signed [14:0] temperature;
  logic [1:0]        serial_mode_cmd;

  modport source(output valid, action, motion, temperature, serial_mode_cmd, input ready);
  modport sink(input valid, action, motion, temperature, serial_mode_cmd, output ready);
endinterface

interface fsmc_status_if;
  logic       valid;
  logic       ready;
  logic [6:0] fan_duty;
  logic [1:0] fan_level;
  logic       power_on;
  logic [1:0] mode_now;
  logic       occupied;
  logic [1:0] beeps;

  modport source(output valid, fan_duty, fan_level, power_on, mode_now, occupied, beeps,
                 input ready);
  modport sink(input valid, fan_duty, fan_level, power_on, mode_now, occupied, beeps,
               output ready);
endinterface

// ===== hdl/fsmc_regs.sv =====
module fsmc_regs
  import fsmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       regs;
  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hot_temp        <= HOT_TEMP_RESET;
      regs.warm_temp       <= WARM_TEMP_RESET;
      regs.mild_temp       <= MILD_TEMP_RESET;
      regs.absence_timeout <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (index)
        REG_HOT_TEMP:  regs.hot_temp        <= pwdata[TEMP_W-1:0];
        REG_WARM_TEMP: regs.warm_temp       <= pwdata[TEMP_W-1:0];
        REG_MILD_TEMP: regs.mild_temp       <= pwdata[TEMP_W-1:0];
        REG_TIMEOUT:   regs.absence_timeout <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_HOT_TEMP:  prdata = APB_DATA_W'(regs.hot_temp);
      REG_WARM_TEMP: prdata = APB_DATA_W'(regs.warm_temp);
      REG_MILD_TEMP: prdata = APB_DATA_W'(regs.mild_temp);
      REG_TIMEOUT:   prdata = APB_DATA_W'(regs.absence_timeout);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/fsmc_core.sv =====
module fsmc_core
  import fsmc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     accept,
  input  logic [2:0]               action,
  input  logic                     motion,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [1:0]               serial_mode_cmd,
  output logic [6:0]               fan_duty,
  output logic [1:0]               fan_level,
  output logic                     power_on,
  output logic [1:0]               mode_now,
  output logic                     occupied,
  output logic [1:0]               beeps
);

  logic                 power;
  mode_t                mode;
  logic [1:0]           level;
  logic                 present;
  logic [TIMEOUT_W-1:0] idle;
  logic [1:0]           chirps;

  logic                 power_next;
  mode_t                mode_next;
  logic [1:0]           level_next;
  logic                 present_next;
  logic [TIMEOUT_W-1:0] idle_next;
  logic [1:0]           chirps_next;
  logic [1:0]           beeps_next;
  logic [1:0]           auto_level;
  logic                 chirp_check;

  always_comb begin
    if (temperature >= cfg.hot_temp) begin
      auto_level = 2'd3;
    end else if (temperature >= cfg.warm_temp) begin
      auto_level = 2'd2;
    end else if (temperature >= cfg.mild_temp) begin
      auto_level = 2'd1;
    end else begin
      auto_level = 2'd0;
    end
  end

  always_comb begin
    power_next   = power;
    mode_next    = mode;
    level_next   = level;
    present_next = present;
    idle_next    = idle;
    chirps_next  = chirps;
    beeps_next   = 2'd0;
    chirp_check  = 1'b0;

    if (action == ACT_POWER) begin
      power_next = ~power;
      beeps_next = 2'd1;
      if (power) begin
        level_next = 2'd0;
      end
    end else if (power) begin
      case (serial_mode_cmd)
        SER_AUTO:   mode_next = MODE_AUTO;
        SER_MANUAL: mode_next = MODE_MANUAL;
        default: ;
      endcase

      if (motion) begin
        idle_next    = '0;
        present_next = 1'b1;
      end else begin
        if (idle >= cfg.absence_timeout) begin
          idle_next = cfg.absence_timeout;
        end else begin
          idle_next = idle + 1'b1;
        end
        if (idle_next >= cfg.absence_timeout) begin
          present_next = 1'b0;
        end
      end

      if (present_next) begin
        case (action)
          ACT_MODE: begin
            mode_next  = (mode_next == MODE_AUTO) ? MODE_MANUAL : MODE_AUTO;
            beeps_next = 2'd1;
          end
          ACT_UP: begin
            if (mode_next == MODE_MANUAL) begin
              if (level != LEVEL_MAX) begin
                level_next = level + 1'b1;
              end
              beeps_next = 2'd1;
            end
          end
          ACT_DOWN: begin
            if (mode_next == MODE_MANUAL) begin
              if (level != 2'd0) begin
                level_next = level - 1'b1;
              end
              beeps_next = 2'd1;
            end
          end
          default: ;
        endcase
        if (mode_next == MODE_AUTO) begin
          level_next = auto_level;
        end
        chirp_check = 1'b1;
      end else if (mode_next == MODE_AUTO) begin
        level_next  = auto_level;
        chirp_check = 1'b1;
      end
    end

    // High level chirps on at most three ticks in a row.
    if (chirp_check) begin
      if (level_next == LEVEL_MAX) begin
        if (chirps != CHIRP_MAX) begin
          chirps_next = chirps + 1'b1;
          beeps_next  = beeps_next + 1'b1;
        end
      end else begin
        chirps_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power   <= 1'b1;
      mode    <= MODE_UNSET;
      level   <= 2'd0;
      present <= 1'b1;
      idle    <= '0;
      chirps  <= 2'd0;
    end else if (accept) begin
      power   <= power_next;
      mode    <= mode_next;
      level   <= level_next;
      present <= present_next;
      idle    <= idle_next;
      chirps  <= chirps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fan_duty  <= level_duty(level_next);
      fan_level <= level_next;
      power_on  <= power_next;
      mode_now  <= mode_next;
      occupied  <= present_next;
      beeps     <= beeps_next;
    end
  end

endmodule

// ===== hdl/fan_speed_mode_controller_unit.sv =====
// Fan speed and mode controller. Each word on the tick channel is one control tick and yields
// exactly one status word: duty, level, power, mode, occupancy and the buzzer chirps for that
// tick. The whole update is combinational comparisons and small counters feeding a status
// register, so a tick is taken every cycle and its status word appears in the next cycle;
// the tick channel stalls only while a finished status word is held back by the consumer.
// Thresholds and the absence timeout are APB registers at 0x0, 0x4, 0x8 and 0xC and should be
// written only while no tick is in flight.
module fan_speed_mode_controller_unit
  import fsmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  fsmc_tick_if.sink             tick,
  fsmc_status_if.source         status
);

  cfg_t cfg;
  logic accept;
  logic status_valid;

  fsmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign tick.ready   = !status_valid || status.ready;
  assign accept       = tick.valid && tick.ready;
  assign status.valid = status_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (tick.ready) begin
      status_valid <= tick.valid;
    end
  end

  fsmc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .action          (tick.action),
    .motion          (tick.motion),
    .temperature     (tick.temperature),
    .serial_mode_cmd (tick.serial_mode_cmd),
    .fan_duty        (status.fan_duty),
    .fan_level       (status.fan_level),
    .power_on        (status.power_on),
    .mode_now        (status.mode_now),
    .occupied        (status.occupied),
    .beeps           (status.beeps)
  );

endmodule
